// File: src/ati_pkg.sv
// Package for the audio timestamp interpolator: field widths, action codes
// and the command and status records between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package ati_pkg;

  localparam int TS_W      = 40;  // timestamp width in milliseconds
  localparam int SZ_W      = 24;  // packet size and byte delta width
  localparam int BC_W      = 32;  // running byte count width
  localparam int HELD_W    = 7;   // entries_held field width
  localparam int ACT_W     = 2;   // action code width

  // The divider retires this many quotient bits per cycle.
  localparam int DIV_STEPS  = 2;
  localparam int DIV_CYCLES = TS_W / DIV_STEPS;

  typedef logic [ACT_W-1:0] act_t;

  localparam act_t ACT_PUSH    = 2'd0;
  localparam act_t ACT_CONSUME = 2'd1;
  localparam act_t ACT_CLEAR   = 2'd2;
  localparam act_t ACT_SET     = 2'd3;

  typedef struct packed {
    logic do_push;   // append the request's entry, or flag it as dropped
    logic do_clear;  // empty the queue and zero count and time
    logic do_set;    // overwrite the current time
    logic do_add;    // add the byte delta to the running count
    logic rd_next;   // read the entry after the head instead of the head
    logic pop;       // retire the head entry that the count covers
    logic lat_head;  // capture the head entry read from the queue
    logic lat_next;  // capture the following timestamp read from the queue
    logic md_start;  // start the multiply and divide unit
    logic apply;     // write the interpolated time
    logic out_load;  // load the result register
  } ati_cmd_t;

  typedef struct packed {
    logic bytes_zero;  // byte count of the pending request is zero
    logic empty;       // queue holds no entry
    logic single;      // queue holds exactly one entry
    logic covered;     // running count covers the entry just read
    logic md_done;     // quotient is ready
    logic out_busy;    // result register holds a result that is not taken
  } ati_stat_t;

endpackage

// File: src/ati_if.sv
// Valid/ready channel interfaces for the audio timestamp interpolator:
// the request channel and the result channel. Depends on ati_pkg.
`timescale 1ns / 1ps

interface ati_in_if;
  import ati_pkg::*;

  logic            valid;
  logic            ready;
  logic [ACT_W-1:0] action;
  logic [TS_W-1:0] timestamp_ms;
  logic [SZ_W-1:0] byte_count;

  modport source (output valid, output action, output timestamp_ms, output byte_count,
                  input ready);
  modport sink (input valid, input action, input timestamp_ms, input byte_count,
                output ready);
endinterface

interface ati_out_if;
  import ati_pkg::*;

  logic              valid;
  logic              ready;
  logic [TS_W-1:0]   current_timestamp;
  logic [HELD_W-1:0] entries_held;
  logic              push_dropped;

  modport source (output valid, output current_timestamp, output entries_held,
                  output push_dropped, input ready);
  modport sink (input valid, input current_timestamp, input entries_held,
                input push_dropped, output ready);
endinterface

// File: src/audio_timestamp_interpolator.sv
// Top level of the audio timestamp interpolator: ties the controller and
// the datapath to the request and result channels. Depends on ati_pkg,
// ati_if, ati_ctrl and ati_datapath.
// Usage. Each request on in_chan carries an action: push a (timestamp,
// byte count) entry for a buffered packet, consume a number of played
// bytes, clear everything, or set the current time. Every request yields
// exactly one result on out_chan with the current time, the number of
// queued entries and a flag that a push was refused because the queue
// was full. Requests are handled one at a time; in_chan.ready is high
// only while the block is idle.
// Sequencing. Push, clear, set and a zero-byte consume go straight to loading
// the result register. Any other consume walks the queue, retiring each head
// entry that the count covers, and ends when the queue runs empty or by
// interpolating: the multiplier takes the low and then the high half, then
// a divider retires two quotient bits per cycle over 40 bits.
// Reset. rst_n is synchronous and active low; it empties the queue and
// zeroes the byte count and the current time, but not the queue memory.
// Stalls. A new request can be accepted while a result waits in the output
// register; the next result is held back, and no request taken, until then.
`timescale 1ns / 1ps

module audio_timestamp_interpolator import ati_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  ati_in_if.sink    in_chan,
  ati_out_if.source out_chan
);

  ati_cmd_t  cmd;
  ati_stat_t stat;
  logic      in_ready;

  // The controller decides what each cycle does; the datapath owns all
  // state and reports only the few conditions the controller branches on.
  ati_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_action (in_chan.action),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ati_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_timestamp_ms       (in_chan.timestamp_ms),
    .in_byte_count         (in_chan.byte_count),
    .out_valid             (out_chan.valid),
    .out_ready             (out_chan.ready),
    .out_current_timestamp (out_chan.current_timestamp),
    .out_entries_held      (out_chan.entries_held),
    .out_push_dropped      (out_chan.push_dropped)
  );

  assign in_chan.ready = in_ready;

  // An accepted request always leaves in_ready low in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_ready |=> !in_ready)
    else $error("request accepted while the previous one was still open");

  // The divider only finishes while a consume request is in progress.
  a_div_in_request: assert property (@(posedge clk) disable iff (!rst_n)
    stat.md_done |-> !in_ready)
    else $error("divider finished while the block was idle");

  // A result never overwrites one that the receiver has not yet taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !stat.out_busy)
    else $error("result register loaded while stalled");

  // The queue cannot be empty and hold one entry at the same time.
  a_count_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.empty && stat.single))
    else $error("queue count flags disagree");

endmodule

// File: src/ati_muldiv.sv
// Multiply and divide unit: computes floor(mag * mul / div) with a shared
// 20x24 multiplier for the low, then the high half, and a radix-4
// restoring divider. Depends on ati_pkg. The caller guarantees mul < div.
`timescale 1ns / 1ps

module ati_muldiv import ati_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [TS_W-1:0] mag,
  input  logic [SZ_W-1:0] mul,
  input  logic [SZ_W-1:0] div,
  output logic            done,
  output logic [TS_W-1:0] quo
);

  localparam int HALF   = TS_W / 2;
  localparam int PROD_W = TS_W + SZ_W;
  localparam int PP_W   = HALF + SZ_W;
  localparam int CNT_W  = $clog2(DIV_CYCLES);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LO   = 3'd1;
  localparam logic [2:0] PH_HI   = 3'd2;
  localparam logic [2:0] PH_INIT = 3'd3;
  localparam logic [2:0] PH_DIV  = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  logic [2:0]        phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TS_W-1:0]   mag_r, mag_nxt;
  logic [SZ_W-1:0]   mul_r, mul_nxt;
  logic [SZ_W-1:0]   div_r, div_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [SZ_W-1:0]   rem_r, rem_nxt;
  logic [TS_W-1:0]   quo_r, quo_nxt;
  logic [HALF-1:0]   pp_a;
  logic [PP_W-1:0]   pp;

  // One multiplier serves the low and the high half of the magnitude.
  assign pp_a = (phase_r == PH_LO) ? mag_r[HALF-1:0] : mag_r[TS_W-1:HALF];
  assign pp   = pp_a * mul_r;

  always_comb begin
    logic [SZ_W:0]   trial;
    logic [SZ_W-1:0] rem_v;
    logic [TS_W-1:0] quo_v;

    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    mag_nxt   = mag_r;
    mul_nxt   = mul_r;
    div_nxt   = div_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    rem_v     = rem_r;
    quo_v     = quo_r;
    trial     = '0;

    // The partial remainder stays below the divisor, so each step is one
    // 25-bit compare and subtract.
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {rem_v, quo_v[TS_W-1]};
      quo_v = {quo_v[TS_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        trial    = trial - {1'b0, div_r};
        quo_v[0] = 1'b1;
      end
      rem_v = trial[SZ_W-1:0];
    end

    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          mag_nxt   = mag;
          mul_nxt   = mul;
          div_nxt   = div;
          phase_nxt = PH_LO;
        end
      end
      PH_LO: begin
        prod_nxt  = PROD_W'(pp);
        phase_nxt = PH_HI;
      end
      PH_HI: begin
        prod_nxt  = prod_r + (PROD_W'(pp) << HALF);
        phase_nxt = PH_INIT;
      end
      PH_INIT: begin
        // The quotient fits in TS_W bits, so the top bits start below div.
        rem_nxt   = prod_r[PROD_W-1:TS_W];
        quo_nxt   = prod_r[TS_W-1:0];
        cnt_nxt   = '0;
        phase_nxt = PH_DIV;
      end
      PH_DIV: begin
        rem_nxt = rem_v;
        quo_nxt = quo_v;
        if (cnt_r == CNT_W'(DIV_CYCLES - 1)) begin
          phase_nxt = PH_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    mul_r  <= mul_nxt;
    div_r  <= div_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  assign done = (phase_r == PH_DONE);
  assign quo  = quo_r;

endmodule

// File: src/ati_datapath.sv
// Datapath of the audio timestamp interpolator: entry queue memory, queue
// pointers, byte count, current time, interpolation unit and result register.
// Depends on ati_pkg and ati_muldiv.
`timescale 1ns / 1ps

module ati_datapath import ati_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ati_cmd_t          cmd,
  output ati_stat_t         stat,
  input  logic [TS_W-1:0]   in_timestamp_ms,
  input  logic [SZ_W-1:0]   in_byte_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TS_W-1:0]   out_current_timestamp,
  output logic [HELD_W-1:0] out_entries_held,
  output logic              out_push_dropped
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = TS_W + SZ_W;

  logic [ENT_W-1:0] mem [QUEUE_DEPTH];
  logic [ENT_W-1:0] rd_data_r;
  logic [PTR_W-1:0] rd_addr;
  logic [PTR_W-1:0] tail;
  logic [PTR_W:0]   tail_sum;
  logic [PTR_W-1:0] head_inc;
  logic [TS_W-1:0]  rd_ts;
  logic [SZ_W-1:0]  rd_size;
  logic             full;
  logic             bytes_zero;
  logic             push_ok;
  logic [BC_W:0]    add_sum;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [BC_W-1:0]  consumed_r, consumed_nxt;
  logic [TS_W-1:0]  cur_r, cur_nxt;
  logic             dropped_r, dropped_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [TS_W-1:0]  head_ts_r;
  logic [SZ_W-1:0]  head_size_r;
  logic [TS_W-1:0]  nts_r;
  logic             neg_r;
  logic [TS_W-1:0]  md_mag;
  logic             md_done;
  logic [TS_W-1:0]  md_quo;

  logic [TS_W-1:0]   out_ts_r;
  logic [HELD_W-1:0] out_held_r;
  logic              out_drop_r;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign bytes_zero = (in_byte_count == '0);
  assign push_ok    = cmd.do_push && !bytes_zero && !full;
  assign head_inc   = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_sum   = (PTR_W+1)'(head_r) + (PTR_W+1)'(count_r);
  assign tail       = (tail_sum >= (PTR_W+1)'(QUEUE_DEPTH)) ?
                      PTR_W'(tail_sum - (PTR_W+1)'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
  assign rd_addr    = cmd.rd_next ? head_inc : head_r;
  assign rd_ts      = rd_data_r[ENT_W-1:SZ_W];
  assign rd_size    = rd_data_r[SZ_W-1:0];
  assign add_sum    = {1'b0, consumed_r} + (BC_W+1)'(in_byte_count);

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail] <= {in_timestamp_ms, in_byte_count};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign md_mag = (nts_r >= head_ts_r) ? nts_r - head_ts_r : head_ts_r - nts_r;

  // The byte count is below the head size here, so its low bits are exact.
  ati_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.md_start),
    .mag   (md_mag),
    .mul   (consumed_r[SZ_W-1:0]),
    .div   (head_size_r),
    .done  (md_done),
    .quo   (md_quo)
  );

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    consumed_nxt  = consumed_r;
    cur_nxt       = cur_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r;

    if (cmd.do_push) begin
      dropped_nxt = !bytes_zero && full;
      if (push_ok) begin
        count_nxt = count_r + 1'b1;
      end
    end
    if (cmd.do_clear) begin
      head_nxt     = '0;
      count_nxt    = '0;
      consumed_nxt = '0;
      cur_nxt      = '0;
      dropped_nxt  = 1'b0;
    end
    if (cmd.do_set) begin
      cur_nxt     = in_timestamp_ms;
      dropped_nxt = 1'b0;
    end
    if (cmd.do_add) begin
      consumed_nxt = add_sum[BC_W] ? '1 : add_sum[BC_W-1:0];
      dropped_nxt  = 1'b0;
    end
    if (cmd.pop) begin
      consumed_nxt = consumed_r - BC_W'(rd_size);
      cur_nxt      = rd_ts;
      head_nxt     = head_inc;
      count_nxt    = count_r - 1'b1;
    end
    if (cmd.apply) begin
      cur_nxt = neg_r ? head_ts_r - md_quo : head_ts_r + md_quo;
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      consumed_r  <= '0;
      cur_r       <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      consumed_r  <= consumed_nxt;
      cur_r       <= cur_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_head) begin
      head_ts_r   <= rd_ts;
      head_size_r <= rd_size;
    end
    if (cmd.lat_next) begin
      nts_r <= rd_ts;
    end
    if (cmd.md_start) begin
      neg_r <= (nts_r < head_ts_r);
    end
    if (cmd.out_load) begin
      out_ts_r   <= cur_r;
      out_held_r <= HELD_W'(count_r);
      out_drop_r <= dropped_r;
    end
  end

  assign stat.bytes_zero = bytes_zero;
  assign stat.empty      = (count_r == '0);
  assign stat.single     = (count_r == CNT_W'(1));
  assign stat.covered    = (consumed_r >= BC_W'(rd_size));
  assign stat.md_done    = md_done;
  assign stat.out_busy   = out_valid_r && !out_ready;

  assign out_valid             = out_valid_r;
  assign out_current_timestamp = out_ts_r;
  assign out_entries_held      = out_held_r;
  assign out_push_dropped      = out_drop_r;

endmodule

// File: src/ati_ctrl.sv
// Controller of the audio timestamp interpolator: accepts requests, walks
// the queue while the byte count covers the head and sequences interpolation.
// Depends on ati_pkg.
`timescale 1ns / 1ps

module ati_ctrl import ati_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  act_t      in_action,
  output logic      in_ready,
  input  ati_stat_t stat,
  output ati_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOP   = 3'd1;
  localparam logic [2:0] S_HEAD   = 3'd2;
  localparam logic [2:0] S_NEXT   = 3'd3;
  localparam logic [2:0] S_MSTART = 3'd4;
  localparam logic [2:0] S_MWAIT  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ACT_PUSH: begin
              cmd.do_push = 1'b1;
              state_nxt   = S_FINISH;
            end
            ACT_CONSUME: begin
              cmd.do_add = 1'b1;
              state_nxt  = stat.bytes_zero ? S_FINISH : S_LOOP;
            end
            ACT_CLEAR: begin
              cmd.do_clear = 1'b1;
              state_nxt    = S_FINISH;
            end
            ACT_SET: begin
              cmd.do_set = 1'b1;
              state_nxt  = S_FINISH;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_LOOP: begin
        // The head entry is read at this edge whenever the queue holds one.
        state_nxt = stat.empty ? S_FINISH : S_HEAD;
      end
      S_HEAD: begin
        if (stat.covered) begin
          cmd.pop   = 1'b1;
          state_nxt = S_LOOP;
        end else begin
          cmd.lat_head = 1'b1;
          if (stat.single) begin
            cmd.lat_next = 1'b1;
            state_nxt    = S_MSTART;
          end else begin
            cmd.rd_next = 1'b1;
            state_nxt   = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        cmd.lat_next = 1'b1;
        state_nxt    = S_MSTART;
      end
      S_MSTART: begin
        cmd.md_start = 1'b1;
        state_nxt    = S_MWAIT;
      end
      S_MWAIT: begin
        if (stat.md_done) begin
          cmd.apply = 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sim/tb_audio_timestamp_interpolator.sv
// Self-checking testbench for the audio timestamp interpolator: directed and random
// requests on the input channel, every result checked against an in-bench timeline model.
// Depends on ati_pkg, ati_if and audio_timestamp_interpolator.
`timescale 1ns / 1ps

module tb_audio_timestamp_interpolator;
  import ati_pkg::*;

  localparam int QDEPTH = 64;

  // One expected result: the time, the queue level and the drop flag.
  typedef struct packed {
    logic [TS_W-1:0]   now_ms;
    logic [HELD_W-1:0] held;
    logic              dropped;
  } stamp_result_t;

  logic clk = 1'b0;
  logic rst_n;

  ati_in_if  in_chan();
  ati_out_if out_chan();

  audio_timestamp_interpolator #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #1 clk = ~clk;

  // Timeline model state. The entry stores are only read for held entries,
  // so their contents after reset do not matter.
  logic [TS_W-1:0] entry_time [QDEPTH];
  logic [SZ_W-1:0] entry_size [QDEPTH];
  int unsigned     q_head;
  int unsigned     q_count;
  logic [BC_W-1:0] played_bytes;
  logic [TS_W-1:0] now_ms;

  // Results predicted for accepted requests, oldest first.
  stamp_result_t pending_results[$];
  int unsigned   fail_count = 0;

  // Idling on either side can be switched off to get back-to-back stretches.
  bit src_gaps_on    = 1'b1;
  bit sink_stalls_on = 1'b1;

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    fail_count++;
    $display("[%0t] mismatch in %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  function automatic void reset_timeline();
    q_head       = 0;
    q_count      = 0;
    played_bytes = '0;
    now_ms       = '0;
  endfunction

  // Applies one request to the timeline model and returns the result it yields.
  function automatic stamp_result_t advance_timeline(act_t act, logic [TS_W-1:0] ts,
                                                     logic [SZ_W-1:0] bc);
    logic [BC_W:0]   sum;
    logic [SZ_W-1:0] sz;
    logic [SZ_W-1:0] div;
    logic [TS_W-1:0] hts;
    logic [TS_W-1:0] nts;
    logic [63:0]     mag;
    logic [63:0]     quo;
    logic            dropped;
    bit              settled;
    stamp_result_t   res;
    dropped = 1'b0;
    case (act)
      ACT_PUSH: begin
        // A zero-size packet is ignored outright; a full queue refuses the entry.
        if (bc != 0) begin
          if (q_count >= QDEPTH) begin
            dropped = 1'b1;
          end else begin
            entry_time[(q_head + q_count) % QDEPTH] = ts;
            entry_size[(q_head + q_count) % QDEPTH] = bc;
            q_count++;
          end
        end
      end
      ACT_CONSUME: begin
        if (bc != 0) begin
          // The running count saturates instead of wrapping.
          sum = {1'b0, played_bytes} + {{(BC_W - SZ_W + 1){1'b0}}, bc};
          played_bytes = sum[BC_W] ? '1 : sum[BC_W-1:0];
          settled = 1'b0;
          while (q_count > 0 && !settled) begin
            sz  = entry_size[q_head];
            hts = entry_time[q_head];
            if (played_bytes >= {{(BC_W - SZ_W){1'b0}}, sz}) begin
              // The head packet has been played out completely.
              played_bytes = played_bytes - {{(BC_W - SZ_W){1'b0}}, sz};
              now_ms       = hts;
              q_head       = (q_head + 1) % QDEPTH;
              q_count--;
            end else begin
              nts = (q_count > 1) ? entry_time[(q_head + 1) % QDEPTH] : hts;
              div = (sz == 0) ? SZ_W'(1) : sz;
              // Interpolate on the magnitude so the step truncates toward zero.
              if (nts >= hts) begin
                mag    = {24'b0, nts - hts};
                quo    = (mag * {32'b0, played_bytes}) / {40'b0, div};
                now_ms = hts + quo[TS_W-1:0];
              end else begin
                mag    = {24'b0, hts - nts};
                quo    = (mag * {32'b0, played_bytes}) / {40'b0, div};
                now_ms = hts - quo[TS_W-1:0];
              end
              settled = 1'b1;
            end
          end
        end
      end
      ACT_CLEAR: begin
        reset_timeline();
      end
      default: begin
        now_ms = ts;
      end
    endcase
    res.now_ms  = now_ms;
    res.held    = HELD_W'(q_count);
    res.dropped = dropped;
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Sends one request and records its expected result once it is accepted.
  // Valid is only lowered when a gap follows, so it never drops and rises
  // again within one time step.
  task automatic issue_request(act_t act, logic [TS_W-1:0] ts, logic [SZ_W-1:0] bc);
    int unsigned gap;
    gap = src_gaps_on ? pick_idle_len() : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.action       <= act;
    in_chan.timestamp_ms <= ts;
    in_chan.byte_count   <= bc;
    do @(posedge clk); while (!in_chan.ready);
    pending_results.push_back(advance_timeline(act, ts, bc));
  endtask

  // Holds the sender back until every outstanding result has been taken.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls on ready, switched off in some stretches.
  initial begin
    int unsigned hold;
    hold = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_chan.ready <= 1'b0;
        hold--;
      end else begin
        out_chan.ready <= 1'b1;
        if (sink_stalls_on && $urandom_range(3) == 0) hold = pick_idle_len();
      end
    end
  end

  // Every result taken by the sink is compared with the oldest expectation.
  always @(posedge clk) begin
    stamp_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, time", 0, out_chan.current_timestamp);
      end else begin
        want = pending_results.pop_front();
        if (out_chan.current_timestamp !== want.now_ms)
          report_mismatch("current_timestamp", want.now_ms, out_chan.current_timestamp);
        if (out_chan.entries_held !== want.held)
          report_mismatch("entries_held", want.held, out_chan.entries_held);
        if (out_chan.push_dropped !== want.dropped)
          report_mismatch("push_dropped", want.dropped, out_chan.push_dropped);
      end
    end
  end

  // Short directed pass: every action, field extremes, a forward and a
  // backward interpolation, truncation, zero-size push and zero consume.
  task automatic test_directed();
    issue_request(ACT_CONSUME, '0, 24'd5);          // consume with nothing queued
    issue_request(ACT_CONSUME, '0, '0);             // zero-byte consume
    issue_request(ACT_SET, '1, '0);                 // largest timestamp
    issue_request(ACT_PUSH, 40'd1000, '0);          // zero-size packet is ignored
    issue_request(ACT_CLEAR, '0, '0);
    issue_request(ACT_PUSH, 40'd1000, 24'd100);
    issue_request(ACT_PUSH, 40'd2000, 24'd200);
    issue_request(ACT_CONSUME, '0, 24'd50);         // halfway into the first packet
    issue_request(ACT_CONSUME, '0, 24'd50);         // pops it, single entry left
    issue_request(ACT_PUSH, 40'd1500, 24'd400);     // earlier than the head
    issue_request(ACT_CONSUME, '0, 24'd100);        // interpolates downward
    issue_request(ACT_CONSUME, '0, 24'd7);          // step is truncated
    issue_request(ACT_PUSH, '1, '1);
    issue_request(ACT_SET, '0, '0);
    issue_request(ACT_CONSUME, '0, '1);             // largest delta
    issue_request(ACT_PUSH, '0, 24'd1);
    issue_request(ACT_CLEAR, '0, '0);
    issue_request(ACT_PUSH, 40'h80_0000_0000, 24'h80_0000);
    issue_request(ACT_PUSH, 40'h7F_FFFF_FFFF, 24'h7F_FFFF);
    issue_request(ACT_CONSUME, '0, 24'h7F_FFFF);
    issue_request(ACT_CONSUME, '0, 24'd1);
    issue_request(ACT_CLEAR, '0, '0);
    drain_results();
  endtask

  // Fills the queue past its depth, retires half and refills across the
  // wrap of the write position.
  task automatic test_queue_full();
    issue_request(ACT_CLEAR, '0, '0);
    for (int i = 0; i < QDEPTH + 2; i++) begin
      issue_request(ACT_PUSH, TS_W'(i * 10), 24'd16);
    end
    issue_request(ACT_CONSUME, '0, 24'd520);
    for (int i = 0; i < QDEPTH / 2 + 1; i++) begin
      issue_request(ACT_PUSH, TS_W'(1000 + i * 7), SZ_W'(i + 1));
    end
    issue_request(ACT_CONSUME, '0, '1);
    issue_request(ACT_CLEAR, '0, '0);
    drain_results();
  endtask

  // Drives the byte count into saturation on an empty queue, then lets the
  // saturated count retire a few large packets in one consume.
  task automatic test_count_saturation();
    issue_request(ACT_CLEAR, '0, '0);
    for (int i = 0; i < 258; i++) begin
      issue_request(ACT_CONSUME, '0, '1);
    end
    for (int i = 0; i < 3; i++) begin
      issue_request(ACT_PUSH, TS_W'(500 + i), '1);
    end
    issue_request(ACT_CONSUME, '0, 24'd1);
    issue_request(ACT_CLEAR, '0, '0);
    drain_results();
  endtask

  function automatic logic [TS_W-1:0] next_stamp(logic [TS_W-1:0] cur);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 90) return cur + TS_W'($urandom_range(200));
    if (r < 94) return cur - TS_W'($urandom_range(200));
    if (r < 97) return cur + TS_W'($urandom);
    return TS_W'({$urandom, $urandom});
  endfunction

  // Packet sizes stay mostly small so that interpolations are frequent.
  function automatic logic [SZ_W-1:0] pick_packet_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return SZ_W'($urandom_range(4096, 1));
    if (r < 95) return SZ_W'($urandom_range(65535, 1));
    return SZ_W'($urandom_range(24'hFF_FFFF, 1));
  endfunction

  // Played deltas are scaled to the head packet, so most consumes land
  // inside it or just past it.
  function automatic logic [SZ_W-1:0] pick_play_delta();
    int unsigned r;
    int unsigned span;
    r = $urandom_range(99);
    if (r >= 90) return SZ_W'($urandom);
    if (q_count == 0 || r >= 80) return SZ_W'($urandom_range(16, 1));
    span = entry_size[q_head];
    if (r < 50) return SZ_W'($urandom_range(span, 1));
    span = span * 2;
    if (span > 24'hFF_FFFF) span = 24'hFF_FFFF;
    return SZ_W'($urandom_range(span, 1));
  endfunction

  // Random timelines: mostly pushes with rising timestamps and consumes sized
  // to the head packet, with a little noise, sets, clears and zero requests.
  task automatic test_random_timeline(int unsigned n_items);
    logic [TS_W-1:0] ts_cursor;
    logic [TS_W-1:0] ts;
    logic [SZ_W-1:0] bc;
    int unsigned     fill_goal;
    int unsigned     r;
    act_t            act;
    ts_cursor = TS_W'({$urandom, $urandom});
    fill_goal = 8;
    for (int i = 0; i < n_items; i++) begin
      if (i % 250 == 0) begin
        src_gaps_on    = ($urandom_range(2) != 0);
        sink_stalls_on = ($urandom_range(2) != 0);
      end
      if (i % 100 == 0) fill_goal = $urandom_range(70, 0);
      if (i % 400 == 399) drain_results();
      r  = $urandom_range(99);
      ts = ts_cursor;
      bc = '0;
      if (r < 4) begin
        act = act_t'($urandom_range(3));
        ts  = TS_W'({$urandom, $urandom});
        bc  = SZ_W'($urandom);
      end else if (r < 5) begin
        act = ACT_CLEAR;
      end else if (r < 8) begin
        act = ACT_SET;
        ts  = ts_cursor - TS_W'($urandom_range(50));
      end else if (r < 10) begin
        act = (r == 8) ? ACT_PUSH : ACT_CONSUME;
      end else if (q_count < fill_goal && r < 60) begin
        act       = ACT_PUSH;
        ts_cursor = next_stamp(ts_cursor);
        ts        = ts_cursor;
        bc        = pick_packet_size();
      end else begin
        act = ACT_CONSUME;
        bc  = pick_play_delta();
      end
      issue_request(act, ts, bc);
    end
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    drain_results();
  endtask

  // The run is bounded; a hang anywhere ends here.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.action       <= ACT_PUSH;
    in_chan.timestamp_ms <= '0;
    in_chan.byte_count   <= '0;
    reset_timeline();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_queue_full();
    test_count_saturation();
    test_random_timeline(1560);

    // Everything has been answered; watch a while longer for stray results.
    drain_results();
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/ati_pkg.sv
src/ati_if.sv
src/ati_muldiv.sv
src/ati_datapath.sv
src/ati_ctrl.sv
src/audio_timestamp_interpolator.sv
sim/tb_audio_timestamp_interpolator.sv
